[hdl/ecmp_pkg.sv]
// Shared constants, item types and hash helper functions for the ECMP path selector.
`default_nettype none

package ecmp_pkg;

    localparam int MAX_PATHS   = 4;
    localparam int PORT_FIELDS = 4;
    localparam int PATH_LIMIT  = (MAX_PATHS < PORT_FIELDS) ? MAX_PATHS : PORT_FIELDS;
    localparam int PORT_W      = 8;
    localparam int CNT_W       = 3;
    localparam int KEY_BYTES   = 12;

    localparam logic [31:0] MUR_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MUR_C2 = 32'h1b873593;
    localparam logic [31:0] MUR_N  = 32'he6546b64;
    localparam logic [31:0] FMIX_1 = 32'h85ebca6b;
    localparam logic [31:0] FMIX_2 = 32'hc2b2ae35;

    localparam logic [7:0] PROTO_TCP  = 8'h06;
    localparam logic [7:0] PROTO_UDP  = 8'h11;
    localparam logic [7:0] PROTO_ACK  = 8'hFC;
    localparam logic [7:0] PROTO_NACK = 8'hFD;

    typedef logic [PORT_FIELDS-1:0][PORT_W-1:0] port_list_t;

    // Header fields as they arrive from the input channel.
    typedef struct packed {
        logic [31:0]       src_ip;
        logic [31:0]       dst_ip;
        logic [7:0]        protocol;
        logic [15:0]       src_port;
        logic [15:0]       dst_port;
        logic [CNT_W-1:0]  path_count;
        port_list_t        ports;
    } flow_t;

    // Routing side information that travels beside the hash.
    typedef struct packed {
        logic              bad;
        logic [CNT_W-1:0]  count;
        port_list_t        ports;
    } route_t;

    typedef struct packed {
        logic [2:0][31:0]  k;
        route_t            route;
    } keys_t;

    typedef struct packed {
        logic [31:0]       h;
        route_t            route;
    } hash_t;

    function automatic logic [31:0] rotl15(input logic [31:0] x);
        return {x[16:0], x[31:17]};
    endfunction

    // One body round of the hash: xor in the key word, rotate left by 13, times 5, plus the round constant.
    function automatic logic [31:0] mur_round(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] x;
        logic [31:0] r;
        x = h ^ k;
        r = {x[18:0], x[31:19]};
        return (r << 2) + r + MUR_N;
    endfunction

endpackage

`default_nettype wire

[hdl/ecmp_key_mix.sv]
// Two pipeline stages that scramble the three key words and qualify the route fields.
`default_nettype none

module ecmp_key_mix
    import ecmp_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire flow_t in_flow,
    output logic       out_valid,
    input  wire logic  out_ready,
    output keys_t      out_keys
);

    logic   v1_reg, v2_reg;
    logic   ld1, ld2;
    keys_t  s1_reg, s1_next;
    keys_t  s2_reg, s2_next;

    assign ld2      = !v2_reg || out_ready;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    always_comb begin
        logic [2:0][31:0] w;
        logic [CNT_W-1:0] cnt;
        w   = {{in_flow.dst_port, in_flow.src_port}, in_flow.dst_ip, in_flow.src_ip};
        cnt = in_flow.path_count;
        if (cnt == '0) begin
            cnt = CNT_W'(1);
        end else if (cnt > CNT_W'(PATH_LIMIT)) begin
            cnt = CNT_W'(PATH_LIMIT);
        end
        for (int i = 0; i < 3; i++) begin
            s1_next.k[i] = w[i] * MUR_C1;
        end
        s1_next.route.bad   = !((in_flow.protocol == PROTO_TCP) ||
                                (in_flow.protocol == PROTO_UDP) ||
                                (in_flow.protocol == PROTO_ACK) ||
                                (in_flow.protocol == PROTO_NACK));
        s1_next.route.count = cnt;
        s1_next.route.ports = in_flow.ports;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s2_next.k[i] = rotl15(s1_reg.k[i]) * MUR_C2;
        end
        s2_next.route = s1_reg.route;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (ld1) begin
                v1_reg <= in_valid;
            end
            if (ld2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            s1_reg <= s1_next;
        end
        if (ld2) begin
            s2_reg <= s2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_keys  = s2_reg;

endmodule

`default_nettype wire

[hdl/ecmp_hash_core.sv]
// Four pipeline stages: hash body rounds under the seed, then the first finalizer steps.
`default_nettype none

module ecmp_hash_core
    import ecmp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [31:0] seed,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire keys_t       in_keys,
    output logic             out_valid,
    input  wire logic        out_ready,
    output hash_t            out_hash
);

    logic  v3_reg, v4_reg, v5_reg, v6_reg;
    logic  ld3, ld4, ld5, ld6;
    logic  [31:0] k2_reg;
    hash_t s3_reg, s3_next;
    hash_t s4_reg, s4_next;
    hash_t s5_reg, s5_next;
    hash_t s6_reg, s6_next;

    assign ld6      = !v6_reg || out_ready;
    assign ld5      = !v5_reg || ld6;
    assign ld4      = !v4_reg || ld5;
    assign ld3      = !v4_reg || ld4 || !v3_reg;
    assign in_ready = !v3_reg || ld4;

    always_comb begin
        s3_next.h     = mur_round(mur_round(seed, in_keys.k[0]), in_keys.k[1]);
        s3_next.route = in_keys.route;
    end

    always_comb begin
        logic [31:0] h;
        h = mur_round(s3_reg.h, k2_reg) ^ 32'(KEY_BYTES);
        s4_next.h     = h ^ (h >> 16);
        s4_next.route = s3_reg.route;
    end

    always_comb begin
        s5_next.h     = s4_reg.h * FMIX_1;
        s5_next.route = s4_reg.route;
    end

    always_comb begin
        s6_next.h     = (s5_reg.h ^ (s5_reg.h >> 13)) * FMIX_2;
        s6_next.route = s5_reg.route;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                v3_reg <= in_valid;
            end
            if (ld4) begin
                v4_reg <= v3_reg;
            end
            if (ld5) begin
                v5_reg <= v4_reg;
            end
            if (ld6) begin
                v6_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && ld3) begin
            s3_reg <= s3_next;
            k2_reg <= in_keys.k[2];
        end
        if (ld4) begin
            s4_reg <= s4_next;
        end
        if (ld5) begin
            s5_reg <= s5_next;
        end
        if (ld6) begin
            s6_reg <= s6_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_hash  = s6_reg;

endmodule

`default_nettype wire

[hdl/ecmp_path_pick.sv]
// Two pipeline stages: last finalizer step, hash modulo path count, next-hop port select.
`default_nettype none

module ecmp_path_pick
    import ecmp_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire hash_t         in_hash,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [PORT_W-1:0]  out_port,
    output logic [31:0]        hash_value,
    output logic               bad_protocol
);

    logic  v7_reg, v8_reg;
    logic  ld7, ld8;
    hash_t s7_reg, s7_next;
    logic  [5:0] dsum_reg, dsum_next;
    logic  [PORT_W-1:0] port_reg, port_next;
    logic  [31:0] hash_reg, hash_next;
    logic  bad_reg, bad_next;

    assign ld8      = !v8_reg || out_ready;
    assign ld7      = !v7_reg || ld8;
    assign in_ready = ld7;

    // Since 4 is 1 mod 3, the sum of the base-4 digits keeps the hash's residue mod 3.
    always_comb begin
        logic [31:0] h;
        h         = in_hash.h ^ (in_hash.h >> 16);
        dsum_next = '0;
        for (int i = 0; i < 16; i++) begin
            dsum_next = dsum_next + 6'(h[2*i +: 2]);
        end
        s7_next.h     = h;
        s7_next.route = in_hash.route;
    end

    always_comb begin
        logic [3:0] t;
        logic [1:0] mod3;
        logic [1:0] idx;
        t = 4'(dsum_reg[1:0]) + 4'(dsum_reg[3:2]) + 4'(dsum_reg[5:4]);
        if (t >= 4'd6) begin
            t = t - 4'd6;
        end
        if (t >= 4'd3) begin
            t = t - 4'd3;
        end
        mod3 = t[1:0];
        case (s7_reg.route.count)
            3'd2:    idx = {1'b0, s7_reg.h[0]};
            3'd3:    idx = mod3;
            3'd4:    idx = s7_reg.h[1:0];
            default: idx = 2'd0;
        endcase
        if (s7_reg.route.bad) begin
            port_next = '0;
            hash_next = '0;
        end else begin
            port_next = s7_reg.route.ports[idx];
            hash_next = s7_reg.h;
        end
        bad_next = s7_reg.route.bad;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else begin
            if (ld7) begin
                v7_reg <= in_valid;
            end
            if (ld8) begin
                v8_reg <= v7_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld7) begin
            s7_reg   <= s7_next;
            dsum_reg <= dsum_next;
        end
        if (ld8) begin
            port_reg <= port_next;
            hash_reg <= hash_next;
            bad_reg  <= bad_next;
        end
    end

    assign out_valid    = v8_reg;
    assign out_port     = port_reg;
    assign hash_value   = hash_reg;
    assign bad_protocol = bad_reg;

endmodule

`default_nettype wire

[hdl/ecmp_flow_hash_path_select.sv]
// Top level of the ECMP flow-hash path selector: seed register, stream ports, pipeline.
//
//   Channel  Direction  Ports                         Content
//   s_       in         s_tvalid s_tready s_tdata     flow header and next-hop list
//   m_       out        m_tvalid m_tready m_tdata     selected port and flow hash
//                       m_tuser                       unsupported-protocol flag
//   cfg      in         cfg_wr_en cfg_wr_data         hash seed
//
// Eight register stages across the key mix, hash core and path pick; one item is taken
// every cycle while m_tready does not stall. The depth is set by the multiplier stages of
// the key scramble and the finalizer. Reset clears the stage valid bits and the seed.
// A stall on m_tready holds each stage in place; bubbles in the pipe are still filled.
`default_nettype none

module ecmp_flow_hash_path_select
    import ecmp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [31:0] src_ip, [63:32] dst_ip, [71:64] protocol, [87:72] src_port,
    // [103:88] dst_port, [106:104] path_count, [114:107] path_port_0,
    // [122:115] path_port_1, [130:123] path_port_2, [138:131] path_port_3, rest zero
    input  wire logic [143:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [7:0] out_port, [39:8] hash_value
    output logic [39:0]       m_tdata,
    // [0] bad_protocol
    output logic [0:0]        m_tuser,
    input  wire logic         cfg_wr_en,
    input  wire logic [31:0]  cfg_wr_data
);

    logic [31:0] seed_reg;
    flow_t       flow;
    logic        km_valid, km_ready;
    keys_t       km_keys;
    logic        hc_valid, hc_ready;
    hash_t       hc_hash;
    logic [PORT_W-1:0] out_port;
    logic [31:0] hash_value;
    logic        bad_protocol;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (cfg_wr_en) begin
            seed_reg <= cfg_wr_data;
        end
    end

    assign flow.src_ip     = s_tdata[31:0];
    assign flow.dst_ip     = s_tdata[63:32];
    assign flow.protocol   = s_tdata[71:64];
    assign flow.src_port   = s_tdata[87:72];
    assign flow.dst_port   = s_tdata[103:88];
    assign flow.path_count = s_tdata[106:104];
    assign flow.ports[0]   = s_tdata[114:107];
    assign flow.ports[1]   = s_tdata[122:115];
    assign flow.ports[2]   = s_tdata[130:123];
    assign flow.ports[3]   = s_tdata[138:131];

    ecmp_key_mix u_key_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_flow   (flow),
        .out_valid (km_valid),
        .out_ready (km_ready),
        .out_keys  (km_keys)
    );

    ecmp_hash_core u_hash_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .seed      (seed_reg),
        .in_valid  (km_valid),
        .in_ready  (km_ready),
        .in_keys   (km_keys),
        .out_valid (hc_valid),
        .out_ready (hc_ready),
        .out_hash  (hc_hash)
    );

    ecmp_path_pick u_path_pick (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (hc_valid),
        .in_ready     (hc_ready),
        .in_hash      (hc_hash),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_port     (out_port),
        .hash_value   (hash_value),
        .bad_protocol (bad_protocol)
    );

    assign m_tdata = {hash_value, out_port};
    assign m_tuser = bad_protocol;

endmodule

`default_nettype wire
